// ===== rtl/i2da_pkg.sv =====
package i2da_pkg;

  localparam int VAL_W  = 64;
  localparam int DIGITS = 19;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int CNT_W  = $clog2(VAL_W);
  localparam int REM_W  = $clog2(DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  // Shift-and-add-3 correction of one BCD digit before the next doubling.
  function automatic logic [3:0] dd_adj(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage

// ===== rtl/int_to_decimal_ascii.sv =====
// The first character follows a taken word after the bit-serial binary-to-BCD loop
// over all 64 bits, a pass that skips leading zeros and the load of the output register.
// The input is stalled from the taking of a word until its last character is loaded
// into the output register.
// Reset (rst_n, synchronous, active low) returns the controller to idle and
// empties the output register.
module int_to_decimal_ascii import i2da_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_ascii_char,
  output logic                    out_last
);

  state_t             state_r, state_nxt;
  logic [VAL_W-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               neg_r, neg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         char_r, char_nxt;
  logic               last_r, last_nxt;
  logic               in_take;
  logic               out_load;
  logic [VAL_W-1:0]   raw;
  logic [3:0]         top_digit;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = !out_valid_r || !out_stall;
  assign raw       = in_value;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = dd_adj(bcd_r[4*i +: 4]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          neg_nxt   = raw[VAL_W-1];
          // Two's complement negation also gives the right magnitude for the
          // most negative value when read as unsigned.
          bin_nxt   = raw[VAL_W-1] ? (~raw + {{(VAL_W-1){1'b0}}, 1'b1}) : raw;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        {bcd_nxt, bin_nxt} = {bcd_adj[BCD_W-2:0], bin_r, 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VAL_W - 1)) begin
          rem_nxt   = REM_W'(DIGITS);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && rem_r > REM_W'(1)) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          rem_nxt = rem_r - 1'b1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_load) begin
          char_nxt      = CHAR_MINUS;
          last_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          char_nxt      = CHAR_ZERO + {4'd0, top_digit};
          last_nxt      = (rem_r == REM_W'(1));
          out_valid_nxt = 1'b1;
          bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = char_r;
  assign out_last       = last_r;

endmodule

// ===== rtl/i2da_chk.sv =====
module i2da_chk import i2da_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [7:0]              out_ascii_char,
  input logic                    out_last
);

  // A taken word keeps the input stalled while it is converted.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a word was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ascii_char) && $stable(out_last))
    else $error("stalled output word changed");

  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ascii_char == CHAR_MINUS ||
                   (out_ascii_char >= CHAR_ZERO && out_ascii_char <= CHAR_ZERO + 8'd9)))
    else $error("output character is neither a digit nor a minus sign");

  // The next run needs a full conversion, so nothing follows a taken last word at once.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_stall |=> !out_valid)
    else $error("output word right after the end of a run");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind int_to_decimal_ascii i2da_chk u_i2da_chk (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import i2da_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_WORDS = 150;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [7:0]              out_ascii_char;
  logic                    out_last;

  logic signed [VAL_W-1:0] word_q[$];
  text_char_t              text_q[$];
  int                      n_words;
  int                      words_sent = 0;
  int                      words_taken = 0;
  int                      errors = 0;
  int                      cycles = 0;
  bit                      in_taken = 1'b0;

  int_to_decimal_ascii dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last)
  );

  always #4 clk = ~clk;

  // Expected characters of one word: optional sign, then digits from the top.
  function automatic void push_decimal_text(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] mag;
    logic [3:0]       dig[DIGITS];
    int               n;
    int               k;
    text_char_t       c;
    mag = v[VAL_W-1] ? ~v + 1'b1 : v;
    n = 0;
    do begin
      dig[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0 && n < DIGITS);
    if (v[VAL_W-1]) begin
      c.ch = CHAR_MINUS;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    for (k = n - 1; k >= 0; k--) begin
      c.ch = CHAR_ZERO + 8'(dig[k]);
      c.last = (k == 0);
      text_q.push_back(c);
    end
  endfunction

  // Driver: one new word or a gap per falling edge; a word is held until taken.
  always @(negedge clk) begin
    int idle_pct;
    int stall_pct;
    if (words_sent < n_words / 3) begin
      idle_pct = 9;
      stall_pct = 56;
    end else if (words_sent < 2 * n_words / 3) begin
      idle_pct = 56;
      stall_pct = 9;
    end else begin
      idle_pct = 0;
      stall_pct = 0;
    end
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (word_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_value <= word_q.pop_front();
          in_valid <= 1'b1;
          words_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predicts on each accepted word and checks each accepted character.
  always @(posedge clk) begin
    text_char_t want;
    cycles++;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      push_decimal_text(in_value);
      words_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (text_q.size() == 0) begin
        $display("%0t: unexpected char %0d last %0b", $time, out_ascii_char, out_last);
        errors++;
      end else begin
        want = text_q.pop_front();
        if (out_ascii_char !== want.ch) begin
          $display("%0t: char expected %0d got %0d", $time, want.ch, out_ascii_char);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, out_last);
          errors++;
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d chars still expected", $time, text_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic signed [VAL_W-1:0] v;
    int                      s;
    int                      i;
    // Zero, single digits, digit-count boundaries and both extremes.
    word_q.push_back(64'sd0);
    word_q.push_back(64'sd1);
    word_q.push_back(-64'sd1);
    word_q.push_back(64'sd9);
    word_q.push_back(-64'sd9);
    word_q.push_back(64'sd10);
    word_q.push_back(-64'sd10);
    word_q.push_back(64'sd99);
    word_q.push_back(64'sd100);
    word_q.push_back(64'sh7FFF_FFFF_FFFF_FFFF);
    word_q.push_back(64'sh8000_0000_0000_0000);
    word_q.push_back(64'sh8000_0000_0000_0001);
    word_q.push_back(64'sd999999999999999999);
    word_q.push_back(64'sd1000000000000000000);
    word_q.push_back(-64'sd1000000000000000000);
    word_q.push_back(64'sd4294967296);
    word_q.push_back(64'sd1234567890123456789);
    word_q.push_back(-64'sd987654321);
    word_q.push_back(64'shFFFF_FFFF_0000_0000);
    word_q.push_back(64'sh5555_5555_5555_5555);
    for (i = 0; i < RANDOM_WORDS; i++) begin
      case ($urandom_range(3))
        0: v = {$urandom, $urandom};
        3: begin
          s = int'($urandom_range(2000)) - 1000;
          v = VAL_W'(s);
        end
        default: begin
          // Shifted patterns spread the magnitudes over every digit count.
          v = {$urandom, $urandom} >> $urandom_range(63, 1);
          if ($urandom_range(1)) v = -v;
        end
      endcase
      word_q.push_back(v);
    end
    n_words = word_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (!(words_taken == n_words && text_q.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && text_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
